// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a rising edge outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// Shared types, constants and codes of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int COLOR_W    = 8;
    localparam int HW_W       = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0]  CH_NL = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_CR = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_BS = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_SP = 8'h20;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_COLOR     = 1'b0,
        CFG_CURSOR_VISIBLE = 1'b1
    } cfg_idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT        = 3'd0,
        REQ_DRAW       = 3'd1,
        REQ_READ       = 3'd2,
        REQ_SET_CURSOR = 3'd3,
        REQ_CLEAR      = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CAPTURE,
        CMD_REJECT,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_BACKSPACE,
        CMD_PRINT,
        CMD_DRAW,
        CMD_READ,
        CMD_READ_CAPTURE,
        CMD_SET_CURSOR,
        CMD_CLEAR_START,
        CMD_CLEAR_STEP,
        CMD_SCROLL_STEP,
        CMD_BLANK_STEP,
        CMD_LOAD_OUT
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CHAR_W-1:0]  ch;
    } cell_t;

    typedef struct packed {
        cmd_t cmd;
        logic in_ready;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic             out_free;
        logic [REQ_W-1:0] req_type;
        logic             byte_high;
        logic             is_nl;
        logic             is_cr;
        logic             is_bs;
        logic             pos_ok;
        logic             col_zero;
        logic             last_row;
        logic             last_col;
        logic             copy_done;
        logic             walk_end;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/tcw_if.sv =====
// Request and result channel interfaces of the text console writer.
`default_nettype none

interface tcw_req_if import tcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [CHAR_W-1:0]  byte_in;
    logic [ROW_W-1:0]   row_in;
    logic [COL_W-1:0]   col_in;
    logic [COLOR_W-1:0] cell_color;

    modport source (
        output valid, req_type, byte_in, row_in, col_in, cell_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, byte_in, row_in, col_in, cell_color,
        output ready
    );
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [CHAR_W-1:0] char_out;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [HW_W-1:0]   hw_cursor_offset;

    modport source (
        output valid, status, char_out, cursor_row, cursor_col, hw_cursor_offset,
        input  ready
    );
    modport sink (
        input  valid, status, char_out, cursor_row, cursor_col, hw_cursor_offset,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  ctrl_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        ctrl_cmd.cmd      = CMD_NOP;
        ctrl_cmd.in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl_cmd.cmd = CMD_CLEAR_STEP;
                if (dp_stat.walk_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ctrl_cmd.in_ready = 1'b1;
                if (dp_stat.in_valid)
                begin
                    ctrl_cmd.cmd = CMD_CAPTURE;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                unique case (dp_stat.req_type)
                    REQ_PUT:
                    begin
                        if (dp_stat.byte_high)
                        begin
                            ctrl_cmd.cmd = CMD_REJECT;
                        end
                        else if (dp_stat.is_nl)
                        begin
                            ctrl_cmd.cmd = CMD_NEWLINE;
                            if (dp_stat.last_row)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        else if (dp_stat.is_cr)
                        begin
                            ctrl_cmd.cmd = CMD_RETURN;
                        end
                        else if (dp_stat.is_bs)
                        begin
                            if (!dp_stat.col_zero)
                            begin
                                ctrl_cmd.cmd = CMD_BACKSPACE;
                            end
                        end
                        else
                        begin
                            ctrl_cmd.cmd = CMD_PRINT;
                            if (dp_stat.last_row && dp_stat.last_col)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                    end
                    REQ_DRAW:
                    begin
                        ctrl_cmd.cmd = dp_stat.pos_ok ? CMD_DRAW : CMD_REJECT;
                    end
                    REQ_READ:
                    begin
                        if (dp_stat.pos_ok)
                        begin
                            ctrl_cmd.cmd = CMD_READ;
                            state_next   = ST_READ;
                        end
                        else
                        begin
                            ctrl_cmd.cmd = CMD_REJECT;
                        end
                    end
                    REQ_SET_CURSOR:
                    begin
                        ctrl_cmd.cmd = dp_stat.pos_ok ? CMD_SET_CURSOR : CMD_REJECT;
                    end
                    REQ_CLEAR:
                    begin
                        ctrl_cmd.cmd = CMD_CLEAR_START;
                        state_next   = ST_CLEAR;
                    end
                    default:
                    begin
                        ctrl_cmd.cmd = CMD_REJECT;
                    end
                endcase
            end
            ST_READ:
            begin
                ctrl_cmd.cmd = CMD_READ_CAPTURE;
                state_next   = ST_RESULT;
            end
            ST_SCROLL:
            begin
                ctrl_cmd.cmd = CMD_SCROLL_STEP;
                if (dp_stat.copy_done)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                ctrl_cmd.cmd = CMD_BLANK_STEP;
                if (dp_stat.walk_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_CLEAR:
            begin
                ctrl_cmd.cmd = CMD_CLEAR_STEP;
                if (dp_stat.walk_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (dp_stat.out_free)
                begin
                    ctrl_cmd.cmd = CMD_LOAD_OUT;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tcw_dp.sv =====
// Datapath of the text console writer: screen store, cursor, walk counter and result register.
`default_nettype none

module tcw_dp import tcw_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcw_req_if.sink               req,
    tcw_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             ctrl_cmd,
    output dp_status_t            dp_stat
);

    localparam int NCELLS = ROWS * COLS;
    localparam int ADDR_W = $clog2(NCELLS);

    logic [REQ_W-1:0]   req_type_reg,   req_type_next;
    logic [CHAR_W-1:0]  byte_reg,       byte_next;
    logic [ROW_W-1:0]   row_in_reg,     row_in_next;
    logic [COL_W-1:0]   col_in_reg,     col_in_next;
    logic [COLOR_W-1:0] color_in_reg,   color_in_next;
    logic               status_reg,     status_next;
    logic [CHAR_W-1:0]  rd_reg,         rd_next;
    logic [ROW_W-1:0]   cur_row_reg,    cur_row_next;
    logic [COL_W-1:0]   cur_col_reg,    cur_col_next;
    logic [ADDR_W-1:0]  walk_reg,       walk_next;
    logic               out_valid_reg,  out_valid_next;
    logic [COLOR_W-1:0] text_color_reg, text_color_next;
    logic               cursor_visible_reg, cursor_visible_next;
    logic               out_status_reg, out_status_next;
    logic [CHAR_W-1:0]  out_char_reg,   out_char_next;
    logic [ROW_W-1:0]   out_row_reg,    out_row_next;
    logic [COL_W-1:0]   out_col_reg,    out_col_next;
    logic [HW_W-1:0]    out_hw_reg,     out_hw_next;

    logic [HW_W-1:0]   cur_idx;
    logic [HW_W-1:0]   pos_idx;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] pos_addr;
    cell_t             blank_cell;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    cell_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    cell_t             ram_rdata;

    assign cur_idx  = HW_W'(cur_row_reg) * HW_W'(COLS) + HW_W'(cur_col_reg);
    assign pos_idx  = HW_W'(row_in_reg) * HW_W'(COLS) + HW_W'(col_in_reg);
    assign cur_addr = cur_idx[ADDR_W-1:0];
    assign pos_addr = pos_idx[ADDR_W-1:0];

    assign blank_cell.color = text_color_reg;
    assign blank_cell.ch    = CH_SP;

    assign dp_stat.in_valid  = req.valid;
    assign dp_stat.out_free  = !out_valid_reg || rsp.ready;
    assign dp_stat.req_type  = req_type_reg;
    assign dp_stat.byte_high = byte_reg[CHAR_W-1];
    assign dp_stat.is_nl     = (byte_reg == CH_NL);
    assign dp_stat.is_cr     = (byte_reg == CH_CR);
    assign dp_stat.is_bs     = (byte_reg == CH_BS);
    assign dp_stat.pos_ok    = ({1'b0, row_in_reg} < (ROW_W + 1)'(ROWS))
                            && ({1'b0, col_in_reg} < (COL_W + 1)'(COLS));
    assign dp_stat.col_zero  = (cur_col_reg == '0);
    assign dp_stat.last_row  = (cur_row_reg == ROW_W'(ROWS - 1));
    assign dp_stat.last_col  = (cur_col_reg == COL_W'(COLS - 1));
    assign dp_stat.copy_done = (walk_reg == ADDR_W'(NCELLS - COLS));
    assign dp_stat.walk_end  = (walk_reg == ADDR_W'(NCELLS - 1));

    tcw_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (NCELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        req_type_next       = req_type_reg;
        byte_next           = byte_reg;
        row_in_next         = row_in_reg;
        col_in_next         = col_in_reg;
        color_in_next       = color_in_reg;
        status_next         = status_reg;
        rd_next             = rd_reg;
        cur_row_next        = cur_row_reg;
        cur_col_next        = cur_col_reg;
        walk_next           = walk_reg;
        out_valid_next      = out_valid_reg;
        text_color_next     = text_color_reg;
        cursor_visible_next = cursor_visible_reg;
        out_status_next     = out_status_reg;
        out_char_next       = out_char_reg;
        out_row_next        = out_row_reg;
        out_col_next        = out_col_reg;
        out_hw_next         = out_hw_reg;
        ram_we              = 1'b0;
        ram_waddr           = cur_addr;
        ram_wdata           = blank_cell;
        ram_re              = 1'b0;
        ram_raddr           = pos_addr;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEXT_COLOR:     text_color_next     = cfg_data;
                CFG_CURSOR_VISIBLE: cursor_visible_next = cfg_data[0];
                default: ;
            endcase
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl_cmd.cmd)
            CMD_NOP: ;
            CMD_CAPTURE:
            begin
                req_type_next = req.req_type;
                byte_next     = req.byte_in;
                row_in_next   = req.row_in;
                col_in_next   = req.col_in;
                color_in_next = req.cell_color;
                status_next   = 1'b0;
                rd_next       = '0;
            end
            CMD_REJECT:
            begin
                status_next = 1'b1;
            end
            CMD_NEWLINE:
            begin
                walk_next = '0;
                if (!dp_stat.last_row)
                begin
                    cur_row_next = cur_row_reg + ROW_W'(1);
                    cur_col_next = '0;
                end
            end
            CMD_RETURN:
            begin
                cur_col_next = '0;
            end
            CMD_BACKSPACE:
            begin
                cur_col_next = cur_col_reg - COL_W'(1);
                ram_we       = 1'b1;
                ram_waddr    = cur_addr - ADDR_W'(1);
            end
            CMD_PRINT:
            begin
                walk_next       = '0;
                ram_we          = 1'b1;
                ram_wdata.color = text_color_reg;
                ram_wdata.ch    = byte_reg;
                if (!dp_stat.last_col)
                begin
                    cur_col_next = cur_col_reg + COL_W'(1);
                end
                else if (!dp_stat.last_row)
                begin
                    cur_row_next = cur_row_reg + ROW_W'(1);
                    cur_col_next = '0;
                end
            end
            CMD_DRAW:
            begin
                ram_we          = 1'b1;
                ram_waddr       = pos_addr;
                ram_wdata.color = color_in_reg;
                ram_wdata.ch    = byte_reg;
            end
            CMD_READ:
            begin
                ram_re = 1'b1;
            end
            CMD_READ_CAPTURE:
            begin
                rd_next = ram_rdata.ch;
            end
            CMD_SET_CURSOR:
            begin
                cur_row_next = row_in_reg;
                cur_col_next = col_in_reg;
            end
            CMD_CLEAR_START:
            begin
                walk_next    = '0;
                cur_row_next = '0;
                cur_col_next = '0;
            end
            CMD_CLEAR_STEP:
            begin
                ram_we       = 1'b1;
                ram_waddr    = walk_reg;
                walk_next    = walk_reg + ADDR_W'(1);
                cur_row_next = '0;
                cur_col_next = '0;
            end
            CMD_SCROLL_STEP:
            begin
                // Read the cell one row below and write last cycle's read one row up.
                ram_re    = !dp_stat.copy_done;
                ram_raddr = walk_reg + ADDR_W'(COLS);
                ram_we    = (walk_reg != '0);
                ram_waddr = walk_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (!dp_stat.copy_done)
                begin
                    walk_next = walk_reg + ADDR_W'(1);
                end
            end
            CMD_BLANK_STEP:
            begin
                ram_we       = 1'b1;
                ram_waddr    = walk_reg;
                walk_next    = walk_reg + ADDR_W'(1);
                cur_row_next = ROW_W'(ROWS - 1);
                cur_col_next = '0;
            end
            CMD_LOAD_OUT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = status_reg;
                out_char_next   = rd_reg;
                out_row_next    = cur_row_reg;
                out_col_next    = cur_col_reg;
                out_hw_next     = cursor_visible_reg ? cur_idx : HW_W'(NCELLS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg        <= '0;
            cur_col_reg        <= '0;
            walk_reg           <= '0;
            out_valid_reg      <= 1'b0;
            text_color_reg     <= TEXT_COLOR_RST;
            cursor_visible_reg <= 1'b1;
        end
        else
        begin
            cur_row_reg        <= cur_row_next;
            cur_col_reg        <= cur_col_next;
            walk_reg           <= walk_next;
            out_valid_reg      <= out_valid_next;
            text_color_reg     <= text_color_next;
            cursor_visible_reg <= cursor_visible_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        byte_reg       <= byte_next;
        row_in_reg     <= row_in_next;
        col_in_reg     <= col_in_next;
        color_in_reg   <= color_in_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        out_status_reg <= out_status_next;
        out_char_reg   <= out_char_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_hw_reg     <= out_hw_next;
    end

    assign req.ready            = ctrl_cmd.in_ready;
    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.char_out         = out_char_reg;
    assign rsp.cursor_row       = out_row_reg;
    assign rsp.cursor_col       = out_col_reg;
    assign rsp.hw_cursor_offset = out_hw_reg;

endmodule

`default_nettype wire

// ===== design/text_console_writer_top.sv =====
// Top level of the text console writer: controller, datapath and screen store.
//
// A ROWS x COLS character-cell console. Each request word on req gives exactly one result
// word on rsp. After reset the block clears every cell of its screen store with req.ready low;
// configuration writes are taken during that pass. Put byte, draw cell and set cursor go
// from acceptance through the execute state to the result state; read cell also passes
// through a read state because of the registered read of the screen RAM. Clear screen and
// a put byte that scrolls walk every cell through the single write port of the screen RAM,
// one cell per cycle. A new request is accepted while the previous result still waits in
// the output register.
`default_nettype none

module text_console_writer_top import tcw_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcw_req_if.sink               req,
    tcw_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_stat;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_stat  (dp_stat),
        .ctrl_cmd (ctrl_cmd)
    );

    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl_cmd  (ctrl_cmd),
        .dp_stat   (dp_stat)
    );

endmodule

`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level assertion checker of the text console writer and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_status,
    input logic [CHAR_W-1:0] rsp_char_out,
    input logic [ROW_W-1:0]  rsp_cursor_row,
    input logic [COL_W-1:0]  rsp_cursor_col,
    input logic [HW_W-1:0]   rsp_hw_cursor_offset
);

    `ASSERT_CLK(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_char_out) && $stable(rsp_cursor_row)
            && $stable(rsp_cursor_col) && $stable(rsp_hw_cursor_offset),
        "Stalled result word changed.")

    `ASSERT_CLK(a_one_in_flight, clk, rst_n,
        req_valid && req_ready |=> !req_ready,
        "Request accepted while another request is in progress.")

    `ASSERT_NEVER(a_reject_no_char, clk, rst_n,
        rsp_valid && rsp_status && (rsp_char_out != '0),
        "Rejected request returned a character.")

    `ASSERT_NEVER(a_cursor_on_screen, clk, rst_n,
        rsp_valid && ((int'(rsp_cursor_row) >= ROWS) || (int'(rsp_cursor_col) >= COLS)),
        "Reported cursor lies outside the screen.")

    `ASSERT_NEVER(a_hw_offset_match, clk, rst_n,
        rsp_valid && (rsp_hw_cursor_offset != HW_W'(ROWS * COLS))
            && (rsp_hw_cursor_offset
                != HW_W'(int'(rsp_cursor_row) * COLS + int'(rsp_cursor_col))),
        "Display cursor offset disagrees with cursor row and column.")

endmodule

bind text_console_writer_top tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (req.valid),
    .req_ready            (req.ready),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_char_out         (rsp.char_out),
    .rsp_cursor_row       (rsp.cursor_row),
    .rsp_cursor_col       (rsp.cursor_col),
    .rsp_hw_cursor_offset (rsp.hw_cursor_offset)
);

`default_nettype wire
